// ===== sv/asb_pkg.sv =====
// Package for the ascending block sorter: beat types and cell control.
// Used by asb_cell and ascending_block_sorter; depends on nothing.
`default_nettype none

package asb_pkg;

	localparam int VALUE_W = 32;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      final_item;
	} in_beat_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] sorted_value;
		logic                      last_out;
		logic                      overflowed;
	} out_beat_t;

	// Operation applied to every cell in one cycle; never both at once.
	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/ascending_block_sorter.sv =====
// Top level of the ascending block sorter: a chain of insertion cells plus emit control.
// Depends on asb_pkg and asb_cell.
//
//   channel | direction | handshake          | beat
//   in      | input     | in_valid/in_ready   | asb_pkg::in_beat_t
//   out     | output    | out_valid/out_ready | asb_pkg::out_beat_t
//
// While a block loads, one beat is accepted every cycle; each value is placed in order
// across the cell chain in the cycle it arrives, by one compare in every cell.
// After the final beat, the held values leave from the head cell at one beat per cycle
// that the output register is free; in_ready is low while emitting. Output stalls simply hold the chain.
// Reset clears every valid bit and the control state; no clearing pass is needed.
`default_nettype none

module ascending_block_sorter #(
	parameter int CAPACITY = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire asb_pkg::in_beat_t   in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output asb_pkg::out_beat_t       out_data
);

	localparam logic PH_LOAD = 1'b0;
	localparam logic PH_EMIT = 1'b1;

	logic                               phase_q;
	logic                               drop_q;
	logic                               emit_drop_q;
	logic                               out_valid_q;
	asb_pkg::out_beat_t                 out_data_q;

	asb_pkg::cell_ctrl_t                ctrl;
	logic                               in_fire;
	logic                               emit_step;
	logic                               full;

	logic signed [asb_pkg::VALUE_W-1:0] val_w      [CAPACITY];
	logic                               valid_w    [CAPACITY];
	logic                               lt_w       [CAPACITY];
	logic signed [asb_pkg::VALUE_W-1:0] prev_val_w [CAPACITY];
	logic                               prev_vld_w [CAPACITY];
	logic                               prev_lt_w  [CAPACITY];
	logic signed [asb_pkg::VALUE_W-1:0] next_val_w [CAPACITY];
	logic                               next_vld_w [CAPACITY];

	assign full      = valid_w[CAPACITY-1];
	assign in_ready  = (phase_q == PH_LOAD);
	assign in_fire   = in_valid && in_ready;
	assign emit_step = (phase_q == PH_EMIT) && (!out_valid_q || out_ready);

	always_comb begin
		ctrl.insert = in_fire && !full;
		ctrl.shift  = emit_step;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prev_val_w[i] = '0;
			assign prev_vld_w[i] = 1'b1;
			assign prev_lt_w[i]  = 1'b0;
		end else begin : g_body
			assign prev_val_w[i] = val_w[i-1];
			assign prev_vld_w[i] = valid_w[i-1];
			assign prev_lt_w[i]  = lt_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign next_val_w[i] = '0;
			assign next_vld_w[i] = 1'b0;
		end else begin : g_inner
			assign next_val_w[i] = val_w[i+1];
			assign next_vld_w[i] = valid_w[i+1];
		end

		asb_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.ins_val    (in_data.value),
			.prev_val   (prev_val_w[i]),
			.prev_valid (prev_vld_w[i]),
			.prev_lt    (prev_lt_w[i]),
			.next_val   (next_val_w[i]),
			.next_valid (next_vld_w[i]),
			.val        (val_w[i]),
			.valid      (valid_w[i]),
			.lt         (lt_w[i])
		);
	end

	// The drop flag of a block is latched for its emit phase when the final beat arrives,
	// so the next block can start counting drops at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LOAD;
			drop_q      <= 1'b0;
			emit_drop_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				if (in_data.final_item) begin
					emit_drop_q <= drop_q || full;
					drop_q      <= 1'b0;
					phase_q     <= PH_EMIT;
				end else if (full) begin
					drop_q <= 1'b1;
				end
			end
			if (emit_step) begin
				out_valid_q <= 1'b1;
				if (!valid_w[1]) begin
					phase_q <= PH_LOAD;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_step) begin
			out_data_q.sorted_value <= val_w[0];
			out_data_q.last_out     <= !valid_w[1];
			out_data_q.overflowed   <= emit_drop_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// ===== sv/asb_cell.sv =====
// One cell of the sorting chain: holds one value and its valid bit.
// Depends on asb_pkg for the value width and the cell control struct.
`default_nettype none

module asb_cell (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire asb_pkg::cell_ctrl_t                 ctrl,
	input  wire logic signed [asb_pkg::VALUE_W-1:0]  ins_val,
	input  wire logic signed [asb_pkg::VALUE_W-1:0]  prev_val,
	input  wire logic                                prev_valid,
	input  wire logic                                prev_lt,
	input  wire logic signed [asb_pkg::VALUE_W-1:0]  next_val,
	input  wire logic                                next_valid,
	output logic signed [asb_pkg::VALUE_W-1:0]       val,
	output logic                                     valid,
	output logic                                     lt
);

	logic signed [asb_pkg::VALUE_W-1:0] val_q;
	logic                               valid_q;

	// An empty cell counts as holding plus infinity, so the new value always goes before it.
	always_comb begin
		lt = !valid_q || (ins_val < val_q);
	end

	// On insert, every cell after the insertion point takes its left neighbour's value;
	// the cell at the insertion point itself takes the new value.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			val_q <= next_val;
		end else if (ctrl.insert && lt) begin
			val_q <= prev_lt ? prev_val : ins_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_valid;
		end else if (ctrl.insert && lt) begin
			valid_q <= valid_q | prev_valid;
		end
	end

	assign val   = val_q;
	assign valid = valid_q;

endmodule

`default_nettype wire
